// ----- design/stk_pkg.sv -----
// Shared constants, operation and status codes, and controller/datapath
// interface types for the hardware stack. No dependencies.

package stk_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int DATA_W      = 32;
	localparam int IDX_W       = 6;
	localparam int DEPTH_W     = 7;
	localparam int WIDE_W      = CNT_W + IDX_W;

	localparam logic [1:0] OP_PUSH   = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_SWAP   = 2'd2;
	localparam logic [1:0] OP_ADD    = 2'd3;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_INDEX = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_FEW   = 2'd3;

	typedef struct packed {
		logic load_in;
		logic decode;
		logic do_push;
		logic rd_second;
		logic apply;
		logic shift_start;
		logic shift_step;
		logic pop_count;
		logic load_out;
	} stk_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       err;
		logic       idx_zero;
		logic       one_entry;
		logic       shift_none;
		logic       shift_last;
		logic       out_free;
	} stk_stat_t;

endpackage

// ----- design/stk_dp.sv -----
// Datapath of the hardware stack: input and result registers, entry count,
// cached top value and the store for the entries below the top.
// Depends on stk_pkg.

module stk_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  stk_pkg::stk_cmd_t             cmd,
	output stk_pkg::stk_stat_t            stat,
	input  logic [1:0]                    opcode,
	input  logic signed [stk_pkg::DATA_W-1:0] value,
	input  logic [stk_pkg::IDX_W-1:0]     index,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic signed [stk_pkg::DATA_W-1:0] top_value,
	output logic [stk_pkg::DEPTH_W-1:0]   depth
);

	logic [1:0]                   op_q;
	logic [stk_pkg::DATA_W-1:0]   val_q;
	logic [stk_pkg::IDX_W-1:0]    idx_q;
	logic [stk_pkg::CNT_W-1:0]    cnt_q;
	logic [stk_pkg::DATA_W-1:0]   top_q;
	logic [stk_pkg::DATA_W-1:0]   rd_q;
	logic [stk_pkg::ADDR_W-1:0]   wr_ptr_q;
	logic [1:0]                   st_q;
	logic                         out_valid_q;
	logic [1:0]                   out_status_q;
	logic [stk_pkg::DATA_W-1:0]   out_top_q;
	logic [stk_pkg::DEPTH_W-1:0]  out_depth_q;

	// Entries below the top; the top itself lives in top_q.
	logic [stk_pkg::DATA_W-1:0]   mem [stk_pkg::STACK_DEPTH];

	logic [stk_pkg::CNT_W-1:0]    cnt_m1, cnt_m2, cnt_m3;
	logic [stk_pkg::WIDE_W-1:0]   idx_w, cnt_w, pos_w;
	logic [stk_pkg::ADDR_W-1:0]   pos;
	logic [1:0]                   st_d;
	logic                         mem_we;
	logic [stk_pkg::ADDR_W-1:0]   mem_wa, mem_ra;
	logic [stk_pkg::DATA_W-1:0]   mem_wd;
	logic [stk_pkg::CNT_W+stk_pkg::DEPTH_W-1:0] depth_ext;

	assign cnt_m1 = cnt_q - stk_pkg::CNT_W'(1);
	assign cnt_m2 = cnt_q - stk_pkg::CNT_W'(2);
	assign cnt_m3 = cnt_q - stk_pkg::CNT_W'(3);
	assign idx_w  = {stk_pkg::CNT_W'(0), idx_q};
	assign cnt_w  = {stk_pkg::IDX_W'(0), cnt_q};
	// Memory slot of the entry being removed when it is not the top.
	assign pos_w  = cnt_w - stk_pkg::WIDE_W'(1) - idx_w;
	assign pos    = pos_w[stk_pkg::ADDR_W-1:0];

	always_comb begin
		case (op_q)
			stk_pkg::OP_PUSH: begin
				st_d = (cnt_q == stk_pkg::CNT_W'(stk_pkg::STACK_DEPTH)) ?
					stk_pkg::ST_FULL : stk_pkg::ST_DONE;
			end
			stk_pkg::OP_REMOVE: begin
				st_d = (idx_w >= cnt_w) ? stk_pkg::ST_INDEX : stk_pkg::ST_DONE;
			end
			stk_pkg::OP_SWAP, stk_pkg::OP_ADD: begin
				st_d = (cnt_q < stk_pkg::CNT_W'(2)) ? stk_pkg::ST_FEW : stk_pkg::ST_DONE;
			end
			default: begin
				st_d = stk_pkg::ST_DONE;
			end
		endcase
	end

	assign stat.op         = op_q;
	assign stat.err        = (st_d != stk_pkg::ST_DONE);
	assign stat.idx_zero   = (idx_q == stk_pkg::IDX_W'(0));
	assign stat.one_entry  = (cnt_q == stk_pkg::CNT_W'(1));
	assign stat.shift_none = (idx_q == stk_pkg::IDX_W'(1));
	assign stat.shift_last = (stk_pkg::CNT_W'(wr_ptr_q) == cnt_m3);
	assign stat.out_free   = !out_valid_q || out_ready;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = cnt_m2[stk_pkg::ADDR_W-1:0];
		mem_wd = top_q;
		mem_ra = wr_ptr_q + stk_pkg::ADDR_W'(2);
		if (cmd.do_push) begin
			// The old top drops into the store when there is one.
			mem_we = (cnt_q != stk_pkg::CNT_W'(0));
			mem_wa = cnt_m1[stk_pkg::ADDR_W-1:0];
		end
		if (cmd.rd_second) begin
			mem_ra = cnt_m2[stk_pkg::ADDR_W-1:0];
		end
		if (cmd.apply && op_q == stk_pkg::OP_SWAP) begin
			mem_we = 1'b1;
		end
		if (cmd.shift_start) begin
			mem_ra = pos + stk_pkg::ADDR_W'(1);
		end
		if (cmd.shift_step) begin
			// Write the word read last cycle one slot lower; the default read
			// fetches the next one.
			mem_we = 1'b1;
			mem_wa = wr_ptr_q;
			mem_wd = rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[mem_ra];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q  <= opcode;
			val_q <= value;
			idx_q <= index;
		end
		if (cmd.decode) begin
			st_q <= st_d;
		end
		if (cmd.do_push) begin
			top_q <= val_q;
		end else if (cmd.apply) begin
			if (op_q == stk_pkg::OP_ADD) begin
				top_q <= rd_q + top_q;
			end else begin
				top_q <= rd_q;
			end
		end
		if (cmd.shift_start) begin
			wr_ptr_q <= pos;
		end else if (cmd.shift_step) begin
			wr_ptr_q <= wr_ptr_q + stk_pkg::ADDR_W'(1);
		end
		if (cmd.load_out) begin
			out_status_q <= st_q;
			out_top_q    <= (cnt_q == stk_pkg::CNT_W'(0)) ? '0 : top_q;
			out_depth_q  <= depth_ext[stk_pkg::DEPTH_W-1:0];
		end
	end

	assign depth_ext = {stk_pkg::DEPTH_W'(0), cnt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.do_push) begin
				cnt_q <= cnt_q + stk_pkg::CNT_W'(1);
			end else if ((cmd.apply && op_q != stk_pkg::OP_SWAP) || cmd.pop_count) begin
				cnt_q <= cnt_m1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign top_value = out_top_q;
	assign depth     = out_depth_q;

endmodule

// ----- design/stk_ctrl.sv -----
// Controller of the hardware stack: sequences decode, the read of the second
// entry, the close-up sweep of a removal and the hand-off of the result.
// Depends on stk_pkg.

module stk_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  stk_pkg::stk_stat_t stat,
	output stk_pkg::stk_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_APPLY  = 3'd2;
	localparam logic [2:0] S_SHIFT  = 3'd3;
	localparam logic [2:0] S_RESULT = 3'd4;

	logic [2:0] state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.decode = 1'b1;
				state_d    = S_RESULT;
				if (!stat.err) begin
					case (stat.op)
						stk_pkg::OP_PUSH: begin
							cmd.do_push = 1'b1;
						end
						stk_pkg::OP_SWAP, stk_pkg::OP_ADD: begin
							cmd.rd_second = 1'b1;
							state_d       = S_APPLY;
						end
						stk_pkg::OP_REMOVE: begin
							if (stat.idx_zero) begin
								if (stat.one_entry) begin
									cmd.pop_count = 1'b1;
								end else begin
									cmd.rd_second = 1'b1;
									state_d       = S_APPLY;
								end
							end else if (stat.shift_none) begin
								cmd.pop_count = 1'b1;
							end else begin
								cmd.shift_start = 1'b1;
								state_d         = S_SHIFT;
							end
						end
						default: begin
							state_d = S_RESULT;
						end
					endcase
				end
			end
			S_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = S_RESULT;
			end
			S_SHIFT: begin
				cmd.shift_step = 1'b1;
				if (stat.shift_last) begin
					cmd.pop_count = 1'b1;
					state_d       = S_RESULT;
				end
			end
			S_RESULT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- design/stack_push_pop_swap_add.sv -----
// Top level of the hardware stack: joins the controller and the datapath.
// Depends on stk_pkg, stk_ctrl and stk_dp.
//
//   channel  handshake            fields
//   in       in_valid / in_ready  opcode, value, index
//   out      out_valid/ out_ready status, top_value, depth
//
// One word is in work at a time. Push, errors and removal of the only entry or of
// the one just below the top go from decode straight to the result state; swap,
// add and removal of the top of a deeper stack pass through the apply state first;
// removal at index i of 2 or more moves each entry above it down in the shift state.
// A result waits in the output register while out_ready is low; the next word
// is accepted once the current result has been loaded there.
// Reset empties the stack; the entry store itself is not cleared.

module stack_push_pop_swap_add (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          opcode,
	input  logic signed [stk_pkg::DATA_W-1:0]   value,
	input  logic [stk_pkg::IDX_W-1:0]           index,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          status,
	output logic signed [stk_pkg::DATA_W-1:0]   top_value,
	output logic [stk_pkg::DEPTH_W-1:0]         depth
);

	stk_pkg::stk_cmd_t  cmd;
	stk_pkg::stk_stat_t stat;

	stk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	stk_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.opcode    (opcode),
		.value     (value),
		.index     (index),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.top_value (top_value),
		.depth     (depth)
	);

endmodule

// ----- design/stk_checker.sv -----
// Port-level checks for the hardware stack, bound to the top level.
// Depends on stk_pkg and stack_push_pop_swap_add.

module stk_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [1:0]                          status,
	input logic signed [stk_pkg::DATA_W-1:0]   top_value,
	input logic [stk_pkg::DEPTH_W-1:0]         depth
);

	// A stalled result word holds until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(top_value) && $stable(depth))
		else $error("result word changed while stalled");

	a_depth_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> depth <= stk_pkg::DEPTH_W'(stk_pkg::STACK_DEPTH))
		else $error("depth beyond capacity");

	a_full_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == stk_pkg::ST_FULL |->
		depth == stk_pkg::DEPTH_W'(stk_pkg::STACK_DEPTH))
		else $error("full status on a stack that is not full");

	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && depth == '0 |-> top_value == '0)
		else $error("empty stack reports a nonzero top");

	a_few_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == stk_pkg::ST_FEW |-> depth < stk_pkg::DEPTH_W'(2))
		else $error("too-few status with two or more entries");

endmodule

bind stack_push_pop_swap_add stk_checker u_stk_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.status    (status),
	.top_value (top_value),
	.depth     (depth)
);

// ----- tb/tb_stack_push_pop_swap_add.sv -----
// Self-checking testbench for stack_push_pop_swap_add: drives stack words,
// tracks the stack contents itself and checks every reported snapshot.
// Depends on stk_pkg and the stack_push_pop_swap_add RTL.
`timescale 1ns / 100ps

module tb_stack_push_pop_swap_add;
	import stk_pkg::*;

	typedef struct {
		logic [1:0]               op;
		logic signed [DATA_W-1:0] val;
		logic [IDX_W-1:0]         idx;
		bit                       drain;
	} stack_word_t;

	typedef struct {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] top;
		logic [DEPTH_W-1:0]       depth;
	} stack_snap_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] opcode = OP_PUSH;
	logic signed [DATA_W-1:0] value = '0;
	logic [IDX_W-1:0] index = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] status;
	logic signed [DATA_W-1:0] top_value;
	logic [DEPTH_W-1:0] depth;

	stack_word_t op_q[$];
	stack_snap_t snapshot_q[$];

	logic [DATA_W-1:0] shadow_mem [STACK_DEPTH];
	int shadow_cnt = 0;
	int gen_depth = 0;
	int n_words = 1;
	int n_acc = 0;
	int n_rx = 0;
	int n_err = 0;
	int stall_left = 0;
	int status_seen [4] = '{0, 0, 0, 0};
	int max_depth = 0;

	stack_push_pop_swap_add uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .value(value), .index(index),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .top_value(top_value), .depth(depth)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		#3000000;
		$display("Timeout at %0t", $time);
		$display("Test completed with failures");
		$finish;
	end

	// Applies one word to the tracked stack and returns the snapshot it reports.
	function automatic stack_snap_t apply_stack_op(input logic [1:0] op,
			input logic [DATA_W-1:0] val, input logic [IDX_W-1:0] idx);
		stack_snap_t r;
		int pos;
		logic [DATA_W-1:0] t;
		r.status = ST_DONE;
		case (op)
			OP_PUSH: begin
				if (shadow_cnt >= STACK_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					shadow_mem[shadow_cnt] = val;
					shadow_cnt++;
				end
			end
			OP_REMOVE: begin
				if (int'(idx) >= shadow_cnt) begin
					r.status = ST_INDEX;
				end else begin
					// Entries above the removed one slide down by one.
					pos = shadow_cnt - 1 - int'(idx);
					for (int k = pos; k + 1 < shadow_cnt; k++)
						shadow_mem[k] = shadow_mem[k + 1];
					shadow_cnt--;
				end
			end
			OP_SWAP: begin
				if (shadow_cnt < 2) begin
					r.status = ST_FEW;
				end else begin
					t = shadow_mem[shadow_cnt - 1];
					shadow_mem[shadow_cnt - 1] = shadow_mem[shadow_cnt - 2];
					shadow_mem[shadow_cnt - 2] = t;
				end
			end
			default: begin
				if (shadow_cnt < 2) begin
					r.status = ST_FEW;
				end else begin
					shadow_mem[shadow_cnt - 2] = shadow_mem[shadow_cnt - 2] +
						shadow_mem[shadow_cnt - 1];
					shadow_cnt--;
				end
			end
		endcase
		r.top = (shadow_cnt > 0) ? shadow_mem[shadow_cnt - 1] : '0;
		r.depth = shadow_cnt[DEPTH_W-1:0];
		return r;
	endfunction

	// The generator keeps its own depth count only to aim indexes and bursts.
	function automatic void add_word(input logic [1:0] op, input logic [DATA_W-1:0] val,
			input int idx, input bit drain);
		stack_word_t w;
		w.op = op;
		w.val = val;
		w.idx = idx[IDX_W-1:0];
		w.drain = drain;
		op_q.push_back(w);
		case (op)
			OP_PUSH:   if (gen_depth < STACK_DEPTH) gen_depth++;
			OP_REMOVE: if (idx < gen_depth) gen_depth--;
			OP_ADD:    if (gen_depth >= 2) gen_depth--;
			default:   ;
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] rand_value();
		case ($urandom_range(19))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'hFFFF_FFFF;
			3:       return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic int rand_index();
		if (gen_depth > 0 && $urandom_range(99) < 80) begin
			if ($urandom_range(99) < 40)
				return $urandom_range((gen_depth > 1) ? 1 : 0);
			return $urandom_range(gen_depth - 1);
		end
		return $urandom_range(63);
	endfunction

	// Idle rates: sender 36 / receiver 60, then swapped, then no idling.
	function automatic int send_idle_pct();
		case (n_acc * 3 / n_words)
			0:       return 36;
			1:       return 60;
			default: return 0;
		endcase
	endfunction

	function automatic int recv_idle_pct();
		case (n_rx * 3 / n_words)
			0:       return 60;
			1:       return 36;
			default: return 0;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin : drive
		stack_word_t w;
		if (!arst_n) begin
			in_valid <= 1'b0;
			opcode <= OP_PUSH;
			value <= '0;
			index <= '0;
		end else begin
			if (in_valid && in_ready) begin
				snapshot_q.push_back(apply_stack_op(opcode, value, index));
				n_acc++;
			end
			if (!in_valid || in_ready) begin
				// A draining word is held back until every snapshot is in.
				if (op_q.size() != 0 && !(op_q[0].drain && snapshot_q.size() != 0) &&
						$urandom_range(99) >= send_idle_pct()) begin
					w = op_q.pop_front();
					in_valid <= 1'b1;
					opcode <= w.op;
					value <= w.val;
					index <= w.idx;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		stack_snap_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (snapshot_q.size() == 0) begin
					$display("%0t: unexpected word status=%0d top=%0d depth=%0d",
						$time, status, top_value, depth);
					n_err++;
				end else begin
					e = snapshot_q.pop_front();
					if (status !== e.status) begin
						$display("%0t: status expected %0d actual %0d", $time, e.status, status);
						n_err++;
					end
					if (top_value !== e.top) begin
						$display("%0t: top_value expected %0d actual %0d",
							$time, e.top, top_value);
						n_err++;
					end
					if (depth !== e.depth) begin
						$display("%0t: depth expected %0d actual %0d", $time, e.depth, depth);
						n_err++;
					end
				end
				n_rx++;
				status_seen[status]++;
				if (int'(depth) > max_depth)
					max_depth = int'(depth);
				// Long receiver stalls let the input side back up.
				if (n_rx == 300 || n_rx == 1100)
					stall_left = 150;
			end
			if (stall_left != 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct());
			end
		end
	end

	initial begin : stimulus
		int mode;
		int burst;
		int r;
		logic [1:0] op;

		// Errors on an empty and a single-entry stack, wrapping adds, removal at
		// the top, middle and bottom, and indexes at or past the depth.
		add_word(OP_REMOVE, 0, 0, 0);
		add_word(OP_SWAP, 0, 0, 0);
		add_word(OP_ADD, 0, 0, 0);
		add_word(OP_PUSH, 32'h7FFF_FFFF, 0, 0);
		add_word(OP_SWAP, 0, 0, 0);
		add_word(OP_ADD, 0, 0, 0);
		add_word(OP_REMOVE, 0, 1, 0);
		add_word(OP_PUSH, 32'h0000_0001, 0, 0);
		add_word(OP_ADD, 0, 0, 0);
		add_word(OP_PUSH, 32'h8000_0000, 0, 0);
		add_word(OP_ADD, 0, 0, 0);
		add_word(OP_PUSH, 32'hFFFF_FFFF, 0, 0);
		add_word(OP_PUSH, 32'h0000_0000, 0, 0);
		add_word(OP_SWAP, 0, 0, 0);
		add_word(OP_REMOVE, 0, 1, 0);
		add_word(OP_REMOVE, 0, 63, 0);
		add_word(OP_PUSH, 32'h5555_5555, 0, 0);
		add_word(OP_PUSH, 32'hAAAA_AAAA, 0, 0);
		add_word(OP_REMOVE, 0, 3, 0);
		add_word(OP_REMOVE, 0, 0, 0);
		add_word(OP_REMOVE, 0, 0, 0);
		add_word(OP_REMOVE, 0, 0, 0);
		add_word(OP_REMOVE, 0, 63, 0);

		// Fill to the limit after a full drain, push into a full stack, then
		// take out the bottom entry and one just above it.
		add_word(OP_PUSH, rand_value(), 0, 1);
		while (gen_depth < STACK_DEPTH)
			add_word(OP_PUSH, rand_value(), 0, 0);
		repeat (3) add_word(OP_PUSH, rand_value(), 0, 0);
		add_word(OP_REMOVE, 0, 63, 0);
		add_word(OP_REMOVE, 0, 61, 0);

		while (op_q.size() < 1700) begin
			mode = $urandom_range(2);
			burst = (mode == 0) ? $urandom_range(40, 120) : $urandom_range(10, 80);
			repeat (burst) begin
				r = $urandom_range(99);
				case (mode)
					0:       op = (r < 70) ? OP_PUSH : (r < 85) ? OP_REMOVE :
							(r < 93) ? OP_SWAP : OP_ADD;
					1:       op = (r < 20) ? OP_PUSH : (r < 65) ? OP_REMOVE :
							(r < 80) ? OP_SWAP : OP_ADD;
					default: op = r[1:0];
				endcase
				add_word(op, rand_value(), (op == OP_REMOVE) ? rand_index() : $urandom_range(63),
					(op_q.size() == 850));
			end
		end
		n_words = op_q.size();

		@(negedge clk);
		while (op_q.size() != 0 || in_valid || snapshot_q.size() != 0)
			@(negedge clk);
		repeat (80) @(negedge clk);

		$display("Ran %0d stack words: %0d done, %0d bad index, %0d full, %0d too few.",
			n_rx, status_seen[ST_DONE], status_seen[ST_INDEX], status_seen[ST_FULL],
			status_seen[ST_FEW]);
		$display("Deepest stack reported: %0d entries; %0d mismatches.", max_depth, n_err);
		if (n_err == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- stack_push_pop_swap_add.f -----
design/stk_pkg.sv
design/stk_dp.sv
design/stk_ctrl.sv
design/stack_push_pop_swap_add.sv
design/stk_checker.sv
tb/tb_stack_push_pop_swap_add.sv
